// ===== hw/rtl/i2c_display_write_master_assert.svh =====
// Assertion macros used by the port-level checker of the display write master.
`ifndef I2C_DISPLAY_WRITE_MASTER_ASSERT_SVH
`define I2C_DISPLAY_WRITE_MASTER_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define I2CDW_ASSERT_SAME(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("i2cdw assertion failed");

// Condition holds in the cycle after the trigger.
`define I2CDW_ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("i2cdw assertion failed");

`endif

// ===== hw/rtl/i2cdw_pkg.sv =====
// Shared types, constants and the symbol function of the display write master.
package i2cdw_pkg;

  // Bus symbol codes.
  typedef enum logic [1:0] {
    SYM_START = 2'd0,
    SYM_BIT   = 2'd1,
    SYM_ACK   = 2'd2,
    SYM_STOP  = 2'd3
  } symbol_t;

  // Register indexes.
  localparam logic REG_DEVICE_ADDRESS    = 1'b0;
  localparam logic REG_HALF_PERIOD_TICKS = 1'b1;

  localparam logic [7:0] CTRL_CMD  = 8'h00;
  localparam logic [7:0] CTRL_DATA = 8'h40;
  localparam logic [9:0] HP_RESET  = 10'd20;

  // Symbol position counter over the full transaction schedule.
  localparam int IDX_W = 5;
  localparam logic [IDX_W-1:0] K_START    = 5'd0;
  localparam logic [IDX_W-1:0] K_ADDR_ACK = 5'd9;
  localparam logic [IDX_W-1:0] K_CTRL_ACK = 5'd18;
  localparam logic [IDX_W-1:0] K_PAYLOAD  = 5'd19;
  localparam logic [IDX_W-1:0] K_PAY_ACK  = 5'd27;
  localparam logic [IDX_W-1:0] K_STOP     = 5'd28;

  typedef struct packed {
    logic       mode;
    logic [7:0] payload;
    logic       last;
  } item_t;

  typedef struct packed {
    symbol_t symbol;
    logic    sda_level;
    logic    run_end;
  } sym_t;

  // Symbol at position k of the schedule: start, address byte and ack,
  // control byte and ack, payload byte and ack, stop.
  function automatic sym_t sym_at(input logic [IDX_W-1:0] k, input logic [7:0] addr,
                                  input item_t item);
    sym_t             s;
    logic [IDX_W-1:0] bit_idx;
    logic [7:0]       ctrl;
    ctrl      = item.mode ? CTRL_DATA : CTRL_CMD;
    s.run_end = (k == K_STOP) || ((k == K_PAY_ACK) && !item.last);
    s.sda_level = 1'b1;
    bit_idx   = '0;
    if (k == K_START) begin
      s.symbol = SYM_START;
    end else if (k == K_STOP) begin
      s.symbol = SYM_STOP;
    end else if ((k == K_ADDR_ACK) || (k == K_CTRL_ACK) || (k == K_PAY_ACK)) begin
      s.symbol = SYM_ACK;
    end else begin
      s.symbol = SYM_BIT;
      if (k < K_ADDR_ACK) begin
        bit_idx     = K_ADDR_ACK - 5'd1 - k;
        s.sda_level = addr[bit_idx[2:0]];
      end else if (k < K_CTRL_ACK) begin
        bit_idx     = K_CTRL_ACK - 5'd1 - k;
        s.sda_level = ctrl[bit_idx[2:0]];
      end else begin
        bit_idx     = K_PAY_ACK - 5'd1 - k;
        s.sda_level = item.payload[bit_idx[2:0]];
      end
    end
    return s;
  endfunction

endpackage

// ===== hw/rtl/i2cdw_cfg.sv =====
// APB register file holding the device address and the half-period setting.
module i2cdw_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  device_address,
  output logic [9:0]  half_period_ticks
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address    <= '0;
      half_period_ticks <= i2cdw_pkg::HP_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        i2cdw_pkg::REG_DEVICE_ADDRESS:    device_address    <= pwdata[7:0];
        i2cdw_pkg::REG_HALF_PERIOD_TICKS: half_period_ticks <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      i2cdw_pkg::REG_DEVICE_ADDRESS:    prdata = {24'd0, device_address};
      i2cdw_pkg::REG_HALF_PERIOD_TICKS: prdata = {22'd0, half_period_ticks};
      default:                          prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/i2cdw_seq.sv =====
// Input register, symbol position counter and bus state of the write master.
module i2cdw_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  i2cdw_pkg::item_t in_item,
  input  logic [7:0]       device_address,
  output logic             sym_valid,
  input  logic             sym_ready,
  output i2cdw_pkg::sym_t  sym
);

  i2cdw_pkg::item_t                  item;
  logic                              item_valid;
  logic [i2cdw_pkg::IDX_W-1:0]       k;
  logic                              bus_busy;
  logic                              adv;
  logic                              accept;

  assign sym       = i2cdw_pkg::sym_at(k, device_address, item);
  assign sym_valid = item_valid;
  assign adv       = item_valid && sym_ready;
  // Take a new item while the final symbol of the current one moves on.
  assign in_ready  = !item_valid || (adv && sym.run_end);
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      bus_busy   <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
      bus_busy   <= !in_item.last;
    end else if (adv && sym.run_end) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_item;
      k    <= bus_busy ? i2cdw_pkg::K_PAYLOAD : i2cdw_pkg::K_START;
    end else if (adv) begin
      k <= k + 5'd1;
    end
  end

endmodule

// ===== hw/rtl/i2cdw_out_reg.sv =====
// Output register that holds one symbol until the downstream side takes it.
module i2cdw_out_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  i2cdw_pkg::sym_t in_sym,
  output logic            out_valid,
  input  logic            out_ready,
  output i2cdw_pkg::sym_t out_sym
);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_sym <= in_sym;
    end
  end

endmodule

// ===== hw/rtl/i2c_display_write_master.sv =====
// Top level: write-only I2C master that turns display bytes into bus symbols.
// An item is registered in the sequencer, its first symbol then in the output register.
// Throughput: one symbol per cycle while m_tready is high; an item yields 29 symbols
// if it opens and closes a transaction, 28 if it opens one, 9 for a middle byte, 10 for
// a closing one; the sequencer's symbol counter sets these. The next item is taken as
// its predecessor's final symbol enters the output register. Synchronous reset clears
// the bus state to idle, empties both registers and restores the configuration defaults.
module i2c_display_write_master (
  input  logic        clk,
  input  logic        rst,
  // Input item stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] payload
  input  logic        s_tuser,   // [0] mode (0 command, 1 display data)
  input  logic        s_tlast,   // last: close the transaction with a stop
  // Bus symbol stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [1:0] symbol, [2] sda_level, [7:3] zero
  output logic        m_tlast,   // run_end: final symbol caused by an item
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  i2cdw_pkg::item_t in_item;
  i2cdw_pkg::sym_t  seq_sym;
  i2cdw_pkg::sym_t  out_sym;
  logic             seq_valid;
  logic             seq_ready;
  logic [7:0]       device_address;
  logic [9:0]       half_period_ticks;

  // The half-period setting is only held here; the symbol path does not use it,
  // but it is visible through the register read path.
  i2cdw_cfg u_cfg (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .device_address    (device_address),
    .half_period_ticks (half_period_ticks)
  );

  assign in_item.mode    = s_tuser;
  assign in_item.payload = s_tdata;
  assign in_item.last    = s_tlast;

  // The sequencer walks the transaction schedule one symbol per cycle while the output
  // register can take one. Items arriving while a transaction is open skip the start,
  // address and control byte and begin at the payload.
  i2cdw_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .in_item        (in_item),
    .device_address (device_address),
    .sym_valid      (seq_valid),
    .sym_ready      (seq_ready),
    .sym            (seq_sym)
  );

  // The output register decouples a stalled consumer from the sequencer.
  i2cdw_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (seq_valid),
    .in_ready  (seq_ready),
    .in_sym    (seq_sym),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_sym   (out_sym)
  );

  assign m_tdata = {5'd0, out_sym.sda_level, out_sym.symbol};
  assign m_tlast = out_sym.run_end;

endmodule

// ===== hw/rtl/i2cdw_checker.sv =====
// Port-level checker for the display write master and its bind.
`include "i2c_display_write_master_assert.svh"

module i2cdw_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  logic is_start;
  logic is_stop;
  logic is_bit;

  assign is_start = m_tdata[1:0] == i2cdw_pkg::SYM_START;
  assign is_stop  = m_tdata[1:0] == i2cdw_pkg::SYM_STOP;
  assign is_bit   = m_tdata[1:0] == i2cdw_pkg::SYM_BIT;

  // A stalled symbol is held unchanged.
  `I2CDW_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata) && $stable(m_tlast))
  // An accepted item reaches the output register as a valid symbol.
  `I2CDW_ASSERT_NEXT(a_first_sym, clk, rst, s_tvalid && s_tready, ##1 m_tvalid)
  // A stop always ends the run of its item.
  `I2CDW_ASSERT_SAME(a_stop_last, clk, rst, m_tvalid && is_stop, m_tlast)
  // A start never ends a run.
  `I2CDW_ASSERT_SAME(a_start_not_last, clk, rst, m_tvalid && is_start, !m_tlast)
  // Only data bits may pull the line low.
  `I2CDW_ASSERT_SAME(a_released, clk, rst, m_tvalid && !is_bit, m_tdata[2])

endmodule

bind i2c_display_write_master i2cdw_checker u_i2cdw_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ===== bench/i2c_display_write_master_checker.sv =====
`timescale 1ns / 1ps
// Checker for the display write master: predicts the bus symbols and compares them.
module i2c_display_write_master_checker
  import i2cdw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tuser,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  input  logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          pending_symbols,
  output int          mismatch_count
);

  logic [7:0] dev_addr;
  logic [9:0] half_period;
  logic       txn_open;
  sym_t       symbol_fifo[$];
  int         mismatches = 0;

  function automatic void queue_symbol(symbol_t code, logic level);
    sym_t s;
    s.symbol    = code;
    s.sda_level = level;
    s.run_end   = 1'b0;
    symbol_fifo.push_back(s);
  endfunction

  function automatic void queue_byte(logic [7:0] value);
    for (int b = 7; b >= 0; b--) queue_symbol(SYM_BIT, value[b]);
    queue_symbol(SYM_ACK, 1'b1);
  endfunction

  // The control byte only goes out when a transaction opens, so mode is
  // ignored for bytes inside an open transaction.
  function automatic void predict_item(logic mode, logic [7:0] payload, logic last);
    sym_t tail;
    if (!txn_open) begin
      queue_symbol(SYM_START, 1'b1);
      queue_byte(dev_addr);
      queue_byte(mode ? CTRL_DATA : CTRL_CMD);
      txn_open = 1'b1;
    end
    queue_byte(payload);
    if (last) begin
      queue_symbol(SYM_STOP, 1'b1);
      txn_open = 1'b0;
    end
    tail = symbol_fifo.pop_back();
    tail.run_end = 1'b1;
    symbol_fifo.push_back(tail);
  endfunction

  task automatic report(input string what, input sym_t want);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected sym=%0d sda=%0b end=%0b, got data=%02h last=%0b",
               $realtime, what, want.symbol, want.sda_level, want.run_end, m_tdata, m_tlast);
  endtask

  always @(posedge clk) begin
    sym_t want;
    if (rst) begin
      dev_addr    = 8'h00;
      half_period = HP_RESET;
      txn_open    = 1'b0;
      symbol_fifo.delete();
    end else begin
      // Results are retired before new predictions so a stray symbol is never
      // matched against an item accepted on the same edge.
      if (m_tvalid && m_tready) begin
        if (symbol_fifo.size() == 0) begin
          want = '0;
          report("symbol with nothing expected", want);
        end else begin
          want = symbol_fifo.pop_front();
          if (m_tdata[1:0] != want.symbol || m_tdata[2] != want.sda_level ||
              m_tdata[7:3] != 5'd0 || m_tlast != want.run_end)
            report("symbol mismatch", want);
        end
      end
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
        if (paddr[2] == REG_DEVICE_ADDRESS) dev_addr = pwdata[7:0];
        else if (paddr[2] == REG_HALF_PERIOD_TICKS) half_period = pwdata[9:0];
      end
      if (s_tvalid && s_tready) predict_item(s_tuser, s_tdata, s_tlast);
    end
    pending_symbols <= symbol_fifo.size();
    mismatch_count  <= mismatches;
  end

endmodule

// ===== bench/tb_i2c_display_write_master.sv =====
`timescale 1ns / 1ps
// Testbench top for the display write master: stimulus, idling control and verdict.
module tb_i2c_display_write_master;
  import i2cdw_pkg::*;

  // Byte addresses of the two configuration registers.
  localparam logic [2:0] ADDR_DEVICE_ADDRESS = {REG_DEVICE_ADDRESS, 2'b00};
  localparam logic [2:0] ADDR_HALF_PERIOD    = {REG_HALF_PERIOD_TICKS, 2'b00};
  localparam int ITEMS_PER_PHASE = 100;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int DRAIN_CYCLES    = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  int pending_symbols;
  int mismatch_count;
  int send_idle_pct = 0;   // chance in a hundred that the sender idles a cycle
  int recv_stall_pct = 0;  // chance in a hundred that the receiver stalls a cycle
  int quiet_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  i2c_display_write_master dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  i2c_display_write_master_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .pending_symbols(pending_symbols), .mismatch_count(mismatch_count)
  );

  // The receiver decides afresh every cycle whether to take a symbol. With a
  // zero stall rate it is always ready.
  always @(posedge clk) begin
    m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // The watchdog counts cycles in which no handshake of any kind completes.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one item and returns in the time step of its handshake, with
  // tvalid still high so the next item can follow back to back. Idle cycles
  // before the item drop tvalid for a cycle each.
  task automatic send_item(input logic mode, input logic [7:0] payload, input logic last);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= payload;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // A write has a setup phase and an access phase, then waits with psel low
  // so back-to-back writes never touch psel twice in one time step.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Stops offering items and waits until every predicted symbol has come out,
  // then keeps waiting so the sequencer is certainly back at rest.
  task automatic drain_symbols();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_symbols != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int          snd_pct[4];
    int          rcv_pct[4];
    int          sent;
    int          run_len;
    logic        noisy;
    logic [31:0] hp_value;

    snd_pct = '{0, 55, 0, 10};
    rcv_pct = '{0, 0, 55, 10};

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. The first item runs with the reset configuration, so the
    // address byte is all zeros.
    send_item(1'b0, 8'h00, 1'b1);
    drain_symbols();
    write_reg(ADDR_DEVICE_ADDRESS, 32'h0000_00FF);
    write_reg(ADDR_HALF_PERIOD, 32'd1023);
    // Single-byte transactions in both modes, payload extremes.
    send_item(1'b0, 8'hFF, 1'b1);
    send_item(1'b1, 8'hFF, 1'b1);
    send_item(1'b1, 8'h00, 1'b1);
    // A longer transaction: mode flips inside it must not change anything.
    send_item(1'b0, 8'h80, 1'b0);
    send_item(1'b1, 8'h01, 1'b0);
    send_item(1'b0, 8'hAA, 1'b0);
    send_item(1'b1, 8'h55, 1'b1);
    drain_symbols();
    // A half period of zero is held but must leave the symbols alone.
    write_reg(ADDR_DEVICE_ADDRESS, 32'h0000_0000);
    write_reg(ADDR_HALF_PERIOD, 32'd0);
    send_item(1'b1, 8'hFF, 1'b0);
    send_item(1'b0, 8'h00, 1'b1);
    drain_symbols();
    // Upper write-data bits set beyond the register widths.
    write_reg(ADDR_DEVICE_ADDRESS, 32'hFFFF_FFA5);
    write_reg(ADDR_HALF_PERIOD, 32'hFFFF_FC01);
    send_item(1'b0, 8'h5A, 1'b1);
    send_item(1'b1, 8'hC3, 1'b0);
    send_item(1'b0, 8'h3C, 1'b1);
    drain_symbols();

    // Random phases, each with its own idling mix and configuration. Most
    // stimulus is well-formed transactions of a few bytes; about one run in
    // five sets the last flag at random instead.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = snd_pct[phase];
      recv_stall_pct <= rcv_pct[phase];
      case ($urandom_range(3))
        0: hp_value = 32'd0;
        1: hp_value = 32'd1;
        2: hp_value = 32'd1023;
        default: hp_value = {$urandom} >> 22;
      endcase
      write_reg(ADDR_DEVICE_ADDRESS, $urandom);
      write_reg(ADDR_HALF_PERIOD, hp_value);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        run_len = $urandom_range(1, 6);
        noisy   = ($urandom_range(4) == 0);
        for (int i = 0; i < run_len && sent < ITEMS_PER_PHASE; i++) begin
          send_item(1'($urandom_range(1)), 8'($urandom_range(255)),
                    noisy ? 1'($urandom_range(1)) : (i == run_len - 1));
          sent++;
        end
      end
      drain_symbols();
    end
    recv_stall_pct <= 0;

    // Everything has been accepted and every expected symbol has arrived.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/i2cdw_pkg.sv
hw/rtl/i2cdw_cfg.sv
hw/rtl/i2cdw_seq.sv
hw/rtl/i2cdw_out_reg.sv
hw/rtl/i2c_display_write_master.sv
hw/rtl/i2cdw_checker.sv
bench/i2c_display_write_master_checker.sv
bench/tb_i2c_display_write_master.sv
